// ----- hdl/bce_pkg.sv -----
// ----------------------------------------------------------------------------
// Blob centroid smoother package
// Shared types and constants for the per-slot centroid smoothing datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

    // Number of blob slots kept in the smoothing store.
    localparam int SLOTS      = 16;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths.
    localparam int SLOT_W  = 4;
    localparam int POS_W   = 16;
    localparam int ALPHA_W = 9;

    // Reset value and upper limit of the smoothing weight (1/256 units).
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(64);
    localparam logic [ALPHA_W-1:0] ALPHA_MAX   = ALPHA_W'(256);

    // Blob status codes.
    typedef enum logic [1:0] {
        ST_NEW     = 2'd0,
        ST_PRESENT = 2'd1,
        ST_MISSING = 2'd2,
        ST_FREE    = 2'd3
    } t_status;

    // Input beat.
    typedef struct packed {
        logic [SLOT_W-1:0] blob_slot;
        logic [1:0]        blob_status;
        logic              was_missing;
        logic [POS_W-1:0]  raw_x;
        logic [POS_W-1:0]  raw_y;
    } t_blob_in;

    // Output beat.
    typedef struct packed {
        logic [POS_W-1:0] out_x;
        logic [POS_W-1:0] out_y;
        logic             was_smoothed;
    } t_blob_out;

    // Per-beat control shared by both coordinate lanes.
    typedef struct packed {
        logic                  write;
        logic                  seed;
        logic                  smooth;
        logic [SLOT_IDX_W-1:0] slot;
        logic [ALPHA_W-1:0]    alpha;
    } t_lane_ctl;

endpackage

`default_nettype wire

// ----- hdl/blob_centroid_ema_smoother_core.sv -----
// ----------------------------------------------------------------------------
// Blob centroid smoother core
// Per-slot exponential moving average of blob centroids, one lane for x and
// one for y, merged into a single result beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  in        input      i_in_valid / o_in_ready  i_in_data  (t_blob_in)
//  out       output     o_out_valid / i_out_ready o_out_data (t_blob_out)
//  cfg       input      i_cfg_we                 i_cfg_data (alpha, 9 bits)
//
//  One beat is accepted per cycle while o_in_ready is high; results are registered.
//  The slot store is read, mixed and written in the accept cycle, so
//  back-to-back beats on the same slot see each other's updates.
//  Reset clears the store to zero and sets alpha to 64.
//  A two-entry output buffer lets one extra beat in while out is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module blob_centroid_ema_smoother_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [bce_pkg::ALPHA_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire bce_pkg::t_blob_in           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output bce_pkg::t_blob_out               o_out_data
);

    logic [bce_pkg::ALPHA_W-1:0] r_alpha;
    logic                        accept;
    logic                        in_range;
    logic                        present;
    bce_pkg::t_lane_ctl          ctl;
    logic [bce_pkg::POS_W-1:0]   lane_x;
    logic [bce_pkg::POS_W-1:0]   lane_y;
    bce_pkg::t_blob_out          merged;

    // Smoothing weight register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= bce_pkg::ALPHA_RESET;
        end else if (i_cfg_we) begin
            r_alpha <= i_cfg_data;
        end
    end

    assign accept = i_in_valid && o_in_ready;

    // Decode the beat into lane control.
    always_comb begin
        in_range  = 32'(i_in_data.blob_slot) < bce_pkg::SLOTS;
        present   = i_in_data.blob_status == bce_pkg::ST_PRESENT;
        ctl.write = accept;
        ctl.seed  = in_range && ((i_in_data.blob_status == bce_pkg::ST_NEW) ||
                                 (present && i_in_data.was_missing));
        ctl.smooth = in_range && present && !i_in_data.was_missing;
        ctl.slot  = i_in_data.blob_slot[bce_pkg::SLOT_IDX_W-1:0];
        ctl.alpha = (r_alpha > bce_pkg::ALPHA_MAX) ? bce_pkg::ALPHA_MAX : r_alpha;
    end

    // Coordinate lanes.
    bce_lane u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_raw   (i_in_data.raw_x),
        .o_val   (lane_x)
    );

    bce_lane u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_raw   (i_in_data.raw_y),
        .o_val   (lane_y)
    );

    // Merge the lane results into one beat.
    always_comb begin
        merged.out_x        = lane_x;
        merged.out_y        = lane_y;
        merged.was_smoothed = ctl.smooth;
    end

    bce_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (merged),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- hdl/bce_lane.sv -----
// ----------------------------------------------------------------------------
// Blob centroid smoother coordinate lane
// Holds the smoothed value of one coordinate for every slot and mixes a raw
// sample into it with a single multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_lane (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire bce_pkg::t_lane_ctl      i_ctl,
    input  wire logic [bce_pkg::POS_W-1:0] i_raw,
    output logic      [bce_pkg::POS_W-1:0] o_val
);

    logic [bce_pkg::POS_W-1:0] r_store [bce_pkg::SLOTS];
    logic [bce_pkg::POS_W-1:0] n_store_val;
    logic [bce_pkg::POS_W-1:0] old_val;
    logic signed [bce_pkg::POS_W:0]     diff;
    logic signed [bce_pkg::ALPHA_W:0]   alpha_s;
    logic signed [bce_pkg::POS_W+bce_pkg::ALPHA_W+1:0] prod;
    logic signed [bce_pkg::POS_W+bce_pkg::ALPHA_W+1:0] prod_sh;
    logic [bce_pkg::POS_W-1:0] mixed;

    // Read the slot being updated.
    assign old_val = r_store[i_ctl.slot];

    // Weighted mix written as old + alpha*(raw - old)/256 with a flooring shift.
    always_comb begin
        diff    = $signed({1'b0, i_raw}) - $signed({1'b0, old_val});
        alpha_s = $signed({1'b0, i_ctl.alpha});
        prod    = (bce_pkg::POS_W + bce_pkg::ALPHA_W + 2)'(alpha_s * diff);
        prod_sh = prod >>> 8;
        mixed   = old_val + prod_sh[bce_pkg::POS_W-1:0];
    end

    // A seed takes the raw sample, a smoothing step takes the mix.
    always_comb begin
        n_store_val = i_ctl.smooth ? mixed : i_raw;
        o_val       = i_ctl.smooth ? mixed : i_raw;
    end

    // Slot store, cleared to zero at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bce_pkg::SLOTS; i++) begin
                r_store[i] <= '0;
            end
        end else if (i_ctl.write && (i_ctl.seed || i_ctl.smooth)) begin
            r_store[i_ctl.slot] <= n_store_val;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bce_out_buf.sv -----
// ----------------------------------------------------------------------------
// Blob centroid smoother output buffer
// Two-entry output register with skid stage, so the input side can take one
// more beat while a result waits for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire bce_pkg::t_blob_out i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output bce_pkg::t_blob_out      o_data
);

    logic               r_main_valid;
    logic               r_skid_valid;
    bce_pkg::t_blob_out r_main;
    bce_pkg::t_blob_out r_skid;
    logic               take;
    logic               push;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign take    = r_main_valid && i_ready;
    assign push    = i_valid && !r_skid_valid;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_main_valid && !take) begin
                r_skid_valid <= 1'b1;
            end
            r_main_valid <= 1'b1;
        end else if (take) begin
            r_main_valid <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_main <= r_skid;
            end
        end else if (push) begin
            if (r_main_valid && !take) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Blob centroid smoother testbench
// Drives blob beats into the smoother core and checks every result beat
// against a per-slot moving-average predictor kept inside the bench. Directed
// tests cover the reset state, each blob status and the alpha extremes. A
// stall test fills the output buffer. Random tests then run blob tracks with
// noise under random idling on both channels. A final stretch runs at full
// rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import bce_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BEATS = 300;
    localparam int PHASES      = 6;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [ALPHA_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    t_blob_in           in_data;
    logic               out_valid;
    logic               out_ready;
    t_blob_out          out_data;

    // Predicted smoothing state.
    logic [ALPHA_W-1:0] model_alpha;
    logic [POS_W-1:0]   model_x [SLOTS];
    logic [POS_W-1:0]   model_y [SLOTS];
    t_blob_out          pending_centroids [$];
    t_blob_out          want_beat;

    // Blob tracks that shape the random stimulus.
    t_status            track_state [SLOTS];
    logic [POS_W-1:0]   track_x [SLOTS];
    logic [POS_W-1:0]   track_y [SLOTS];

    int mismatches;
    int beats_sent;
    int beats_checked;
    int smoothed_seen;
    int alpha_writes;
    int in_gap_pct;
    int out_stall_pct;
    int hold_count;
    bit hold_request;

    blob_centroid_ema_smoother_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Work out the result of one blob beat and update the predicted store.
    function automatic t_blob_out smooth_centroid(input t_blob_in b);
        t_blob_out   r;
        int unsigned a;
        int unsigned sum_x;
        int unsigned sum_y;
        r.out_x        = b.raw_x;
        r.out_y        = b.raw_y;
        r.was_smoothed = 1'b0;
        a = (model_alpha > ALPHA_MAX) ? ALPHA_MAX : model_alpha;
        if (b.blob_slot < SLOTS) begin
            if (b.blob_status == ST_NEW ||
                (b.blob_status == ST_PRESENT && b.was_missing)) begin
                model_x[b.blob_slot] = b.raw_x;
                model_y[b.blob_slot] = b.raw_y;
            end else if (b.blob_status == ST_PRESENT) begin
                sum_x = a * b.raw_x + (256 - a) * model_x[b.blob_slot];
                sum_y = a * b.raw_y + (256 - a) * model_y[b.blob_slot];
                model_x[b.blob_slot] = POS_W'(sum_x >> 8);
                model_y[b.blob_slot] = POS_W'(sum_y >> 8);
                r.out_x        = model_x[b.blob_slot];
                r.out_y        = model_y[b.blob_slot];
                r.was_smoothed = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_blob_in make_blob(input int slot, input t_status st,
                                           input bit wm, input logic [POS_W-1:0] x,
                                           input logic [POS_W-1:0] y);
        t_blob_in b;
        b.blob_slot   = SLOT_W'(slot);
        b.blob_status = st;
        b.was_missing = wm;
        b.raw_x       = x;
        b.raw_y       = y;
        return b;
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return POS_W'($urandom_range(0, 65535));
    endfunction

    // Next beat of a well-formed blob track: new, present, missing, free.
    function automatic t_blob_in track_blob();
        t_blob_in b;
        int       s;
        int       pick;
        s = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, SLOTS - 1);
        pick = $urandom_range(0, 99);
        b.blob_slot   = SLOT_W'(s);
        b.was_missing = 1'b0;
        case (track_state[s])
            ST_FREE: begin
                b.blob_status = ST_NEW;
            end
            ST_MISSING: begin
                if (pick < 60) begin
                    b.blob_status = ST_PRESENT;
                    b.was_missing = 1'b1;
                end else if (pick < 90) begin
                    b.blob_status = ST_MISSING;
                end else begin
                    b.blob_status = ST_FREE;
                end
            end
            default: begin
                if (pick < 80)
                    b.blob_status = ST_PRESENT;
                else if (pick < 90)
                    b.blob_status = ST_MISSING;
                else
                    b.blob_status = ST_FREE;
            end
        endcase
        track_state[s] = t_status'(b.blob_status);
        // Positions wander a little per beat, with an occasional jump.
        if ($urandom_range(0, 19) == 0) begin
            track_x[s] = rand_pos();
            track_y[s] = rand_pos();
        end else begin
            track_x[s] = track_x[s] + POS_W'($urandom_range(0, 1023)) - POS_W'(512);
            track_y[s] = track_y[s] + POS_W'($urandom_range(0, 1023)) - POS_W'(512);
        end
        b.raw_x = track_x[s];
        b.raw_y = track_y[s];
        return b;
    endfunction

    function automatic t_blob_in noise_blob();
        return make_blob($urandom_range(0, SLOTS - 1), t_status'($urandom_range(0, 3)),
                         $urandom_range(0, 1), rand_pos(), rand_pos());
    endfunction

    // Offer one beat, wait for it to be taken, then record its prediction.
    task automatic send_blob(input t_blob_in b);
        if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_data  = b;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_centroids.push_back(smooth_centroid(b));
        beats_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_centroids.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Alpha is only changed while the core is empty.
    task automatic write_alpha(input logic [ALPHA_W-1:0] value);
        wait_drain();
        cfg_data = value;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we      = 1'b0;
        model_alpha = value;
        alpha_writes++;
    endtask

    // Reset store is zero and alpha is 64: a present beat mixes with zero.
    task automatic test_reset_defaults();
        send_blob(make_blob(0, ST_PRESENT, 1'b0, '1, '1));
        send_blob(make_blob(SLOTS - 1, ST_PRESENT, 1'b0, '0, '1));
    endtask

    task automatic test_status_cases();
        send_blob(make_blob(1, ST_NEW, 1'b0, '1, '0));
        send_blob(make_blob(1, ST_PRESENT, 1'b0, '0, '1));
        send_blob(make_blob(1, ST_PRESENT, 1'b1, 16'h1234, 16'hABCD));
        send_blob(make_blob(1, ST_MISSING, 1'b0, 16'h5555, 16'hAAAA));
        send_blob(make_blob(1, ST_MISSING, 1'b1, 16'hAAAA, 16'h5555));
        send_blob(make_blob(1, ST_FREE, 1'b0, '0, '0));
        send_blob(make_blob(1, ST_FREE, 1'b1, '1, '1));
        // The store must still hold the seed after missing and free beats.
        send_blob(make_blob(1, ST_PRESENT, 1'b0, 16'h8000, 16'h0001));
        send_blob(make_blob(2, ST_NEW, 1'b1, 16'hFF00, 16'h00FF));
        repeat (3) send_blob(make_blob(2, ST_PRESENT, 1'b0, '0, '1));
    endtask

    // Zero keeps the old value; 256 and above pass the raw value.
    task automatic test_alpha_extremes();
        logic [ALPHA_W-1:0] settings [6];
        settings = '{9'd0, 9'd256, 9'd511, 9'd257, 9'd1, 9'd255};
        foreach (settings[i]) begin
            write_alpha(settings[i]);
            send_blob(make_blob(3, ST_PRESENT, 1'b0, rand_pos(), rand_pos()));
            send_blob(make_blob(3, ST_PRESENT, 1'b0, '1, '0));
        end
    endtask

    // The receiver stalls for a long time while beats keep coming.
    task automatic test_output_stall();
        write_alpha(ALPHA_RESET);
        in_gap_pct    = 0;
        out_stall_pct = 0;
        hold_request  = 1'b1;
        repeat (40) send_blob(track_blob());
        wait (!hold_request);
        wait_drain();
    endtask

    task automatic test_random_tracks();
        int pick;
        for (int p = 0; p < PHASES; p++) begin
            pick = $urandom_range(0, 5);
            case (pick)
                0: write_alpha(9'd0);
                1: write_alpha(9'd256);
                2: write_alpha(9'd511);
                default: write_alpha(ALPHA_W'($urandom_range(0, 511)));
            endcase
            in_gap_pct    = (p == 2) ? 0 : $urandom_range(0, 3) * 20;
            out_stall_pct = (p == 2) ? 0 : $urandom_range(0, 3) * 20;
            for (int i = 0; i < PHASE_BEATS; i++) begin
                if ($urandom_range(0, 99) < 80)
                    send_blob(track_blob());
                else
                    send_blob(noise_blob());
            end
        end
    endtask

    task automatic test_full_rate();
        write_alpha(ALPHA_W'($urandom_range(1, 255)));
        in_gap_pct    = 0;
        out_stall_pct = 0;
        repeat (100) send_blob(track_blob());
    endtask

    // Receiver: random stalls, or one long hold-off on request.
    initial begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_ready = 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(negedge clk);
                hold_request = 1'b0;
                out_ready    = 1'b1;
            end else if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_ready = 1'b1;
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_centroids.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: x=%h y=%h smoothed=%b",
                             out_data.out_x, out_data.out_y, out_data.was_smoothed);
            end else begin
                want_beat = pending_centroids.pop_front();
                beats_checked++;
                if (out_data.was_smoothed === 1'b1)
                    smoothed_seen++;
                if (out_data.out_x !== want_beat.out_x ||
                    out_data.out_y !== want_beat.out_y ||
                    out_data.was_smoothed !== want_beat.was_smoothed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected x=%h y=%h smoothed=%b, got x=%h y=%h smoothed=%b",
                                 beats_checked, want_beat.out_x, want_beat.out_y,
                                 want_beat.was_smoothed, out_data.out_x, out_data.out_y,
                                 out_data.was_smoothed);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        hold_request  = 1'b0;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        model_alpha   = ALPHA_RESET;
        for (int s = 0; s < SLOTS; s++) begin
            model_x[s]     = '0;
            model_y[s]     = '0;
            track_state[s] = ST_FREE;
            track_x[s]     = POS_W'($urandom_range(0, 65535));
            track_y[s]     = POS_W'($urandom_range(0, 65535));
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        in_gap_pct    = 30;
        out_stall_pct = 30;
        test_status_cases();
        test_alpha_extremes();
        test_output_stall();
        test_random_tracks();
        test_full_rate();

        wait_drain();
        repeat (10) @(negedge clk);
        $display("Sent %0d blob beats over %0d alpha settings, including a long output stall.",
                 beats_sent, alpha_writes);
        $display("Checked %0d results, %0d of them smoothed; %0d mismatches.",
                 beats_checked, smoothed_seen, mismatches);
        if (mismatches == 0 && pending_centroids.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/bce_pkg.sv
hdl/bce_lane.sv
hdl/bce_out_buf.sv
hdl/blob_centroid_ema_smoother_core.sv
test/tb.sv
